// ----- hw/rtl/jpeg_coef_quantizer_assert.svh -----
// assertion macros for the jpeg coefficient quantizer
// used by the top level only, no other dependencies
`ifndef JPEG_COEF_QUANTIZER_ASSERT_SVH
`define JPEG_COEF_QUANTIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define JCQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define JCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/jcq_pkg.sv -----
// shared types and constants of the jpeg coefficient quantizer
// no dependencies; imported by every jcq module except jcq_ram
package jcq_pkg;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUANT = 1'b1
    } t_op;

    localparam int IDX_W     = 6;
    localparam int COEF_W    = 16;
    localparam int RECIP_W   = 16;
    localparam int CORR_W    = 16;
    localparam int SHIFT_W   = 4;
    localparam int PROD_W    = COEF_W + RECIP_W;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // one table word: reciprocal, correction, shift
    localparam int TBL_W = RECIP_W + CORR_W + SHIFT_W;

    // queue between front and back; depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COEF_W-1:0]  coef;
        logic [RECIP_W-1:0] recip;
        logic [CORR_W-1:0]  corr;
        logic [SHIFT_W-1:0] shift;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hw/rtl/jcq_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module jcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/jcq_front.sv -----
// front end: accepts words, writes the table on loads, looks it up on quantizes
// depends on jcq_pkg and jcq_ram
module jcq_front
    import jcq_pkg::*;
#(
    parameter int BLOCK_COEFS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  t_op                i_op,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [COEF_W-1:0]  i_coef,
    input  logic [RECIP_W-1:0] i_recip,
    input  logic [CORR_W-1:0]  i_corr,
    input  logic [SHIFT_W-1:0] i_shift,
    input  t_q_status          i_q_stat,
    output logic               o_push,
    output t_q_entry           o_entry
);

    localparam int AW = (BLOCK_COEFS > 1) ? $clog2(BLOCK_COEFS) : 1;

    logic              w_accept;
    logic              w_in_range;
    logic              w_we;
    logic              w_re;
    logic [AW-1:0]     w_addr;
    logic [TBL_W-1:0]  w_rdata;

    logic              r_s1_valid;
    logic [IDX_W-1:0]  r_s1_index;
    logic [COEF_W-1:0] r_s1_coef;
    logic              r_s1_hit;

    assign o_s_tready = !r_s1_valid || !i_q_stat.full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_range = (32'(i_index) < 32'(BLOCK_COEFS));
    assign w_addr     = AW'(i_index);
    assign w_we       = w_accept && (i_op == OP_LOAD) && w_in_range;
    assign w_re       = w_accept && (i_op == OP_QUANT);

    jcq_ram #(
        .WIDTH (TBL_W),
        .DEPTH (BLOCK_COEFS)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata ({i_recip, i_corr, i_shift}),
        .i_re    (w_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_s1_index <= i_index;
            r_s1_coef  <= i_coef;
            r_s1_hit   <= w_in_range;
        end
    end

    // positions beyond the table read as all zero
    assign o_push        = r_s1_valid && !i_q_stat.full;
    assign o_entry.index = r_s1_index;
    assign o_entry.coef  = r_s1_coef;
    assign o_entry.recip = r_s1_hit ? w_rdata[TBL_W-1 -: RECIP_W] : '0;
    assign o_entry.corr  = r_s1_hit ? w_rdata[SHIFT_W +: CORR_W] : '0;
    assign o_entry.shift = r_s1_hit ? w_rdata[SHIFT_W-1:0] : '0;

endmodule

// ----- hw/rtl/jcq_queue.sv -----
// short queue of looked-up quantize jobs between front and back
// depends on jcq_pkg
module jcq_queue
    import jcq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_entry,
    output t_q_status o_stat
);

    t_q_entry           r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry      = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- hw/rtl/jcq_back.sv -----
// back end: magnitude plus correction, multiply, shift and sign restore
// depends on jcq_pkg
module jcq_back
    import jcq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_entry          i_entry,
    input  t_q_status         i_q_stat,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [IDX_W-1:0]  o_position,
    output logic [COEF_W-1:0] o_quantized
);

    logic               w_adv1, w_adv2, w_adv3;
    logic               w_sign;
    logic [COEF_W-1:0]  w_mag;
    logic [COEF_W-1:0]  w_q;

    logic               r_b1_valid;
    logic [IDX_W-1:0]   r_b1_index;
    logic               r_b1_sign;
    logic [COEF_W-1:0]  r_b1_sum;
    logic [RECIP_W-1:0] r_b1_recip;
    logic [SHIFT_W-1:0] r_b1_shift;

    logic               r_b2_valid;
    logic [IDX_W-1:0]   r_b2_index;
    logic               r_b2_sign;
    logic [PROD_W-1:0]  r_b2_prod;
    logic [SHIFT_W-1:0] r_b2_shift;

    logic               r_b3_valid;
    logic [IDX_W-1:0]   r_b3_index;
    logic [COEF_W-1:0]  r_b3_quant;

    assign w_adv3 = !r_b3_valid || i_m_tready;
    assign w_adv2 = !r_b2_valid || w_adv3;
    assign w_adv1 = !r_b1_valid || w_adv2;
    assign o_pop  = !i_q_stat.empty && w_adv1;

    // -32768 comes out as 0x8000, the unsigned magnitude
    assign w_sign = i_entry.coef[COEF_W-1];
    assign w_mag  = w_sign ? (~i_entry.coef + COEF_W'(1)) : i_entry.coef;

    // product >> (shift + 16) taken as the upper half shifted by shift
    assign w_q = r_b2_prod[PROD_W-1 -: COEF_W] >> r_b2_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_b1_valid <= o_pop;
            end
            if (w_adv2) begin
                r_b2_valid <= r_b1_valid;
            end
            if (w_adv3) begin
                r_b3_valid <= r_b2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_index <= i_entry.index;
            r_b1_sign  <= w_sign;
            r_b1_sum   <= w_mag + i_entry.corr;
            r_b1_recip <= i_entry.recip;
            r_b1_shift <= i_entry.shift;
        end
        if (w_adv2 && r_b1_valid) begin
            r_b2_index <= r_b1_index;
            r_b2_sign  <= r_b1_sign;
            r_b2_prod  <= PROD_W'(r_b1_sum) * PROD_W'(r_b1_recip);
            r_b2_shift <= r_b1_shift;
        end
        if (w_adv3 && r_b2_valid) begin
            r_b3_index <= r_b2_index;
            r_b3_quant <= r_b2_sign ? (~w_q + COEF_W'(1)) : w_q;
        end
    end

    assign o_m_tvalid  = r_b3_valid;
    assign o_position  = r_b3_index;
    assign o_quantized = r_b3_quant;

endmodule

// ----- hw/rtl/jpeg_coef_quantizer.sv -----
// jpeg coefficient quantizer, top level: front, queue, back
// throughput: one word per cycle, loads and quantizes mixed freely, unless a full queue holds back the input
// the rate is set by the table's one write and one read port (one access per word) and the multiplier
// reset: i_rst_n synchronous active low clears all valid state; the table is not cleared
`include "jpeg_coef_quantizer_assert.svh"

module jpeg_coef_quantizer
    import jcq_pkg::*;
#(
    parameter int BLOCK_COEFS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // index[5:0], coef[21:6], recip[37:22], corr[53:38], shift[57:54], zero pad [63:58]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // op[0]: 0 load table entry, 1 quantize coefficient
    input  logic [0:0]           i_s_axis_tuser,
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // position[5:0], quantized[21:6], zero pad [23:22]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    // unpacked input word
    t_op                w_op;
    logic [IDX_W-1:0]   w_index;
    logic [COEF_W-1:0]  w_coef;
    logic [RECIP_W-1:0] w_recip;
    logic [CORR_W-1:0]  w_corr;
    logic [SHIFT_W-1:0] w_shift;

    // front to queue to back
    logic      w_push;
    t_q_entry  w_push_entry;
    logic      w_pop;
    t_q_entry  w_pop_entry;
    t_q_status w_q_stat;

    // back result
    logic [IDX_W-1:0]  w_position;
    logic [COEF_W-1:0] w_quantized;

    assign w_op    = t_op'(i_s_axis_tuser[0]);
    assign w_index = i_s_axis_tdata[IDX_W-1:0];
    assign w_coef  = i_s_axis_tdata[IDX_W +: COEF_W];
    assign w_recip = i_s_axis_tdata[IDX_W+COEF_W +: RECIP_W];
    assign w_corr  = i_s_axis_tdata[IDX_W+COEF_W+RECIP_W +: CORR_W];
    assign w_shift = i_s_axis_tdata[IDX_W+COEF_W+RECIP_W+CORR_W +: SHIFT_W];

    // front: loads write the table at once, quantizes read it, wait in the lookup
    // register and then land in the queue with their table word attached
    jcq_front #(
        .BLOCK_COEFS (BLOCK_COEFS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_op       (w_op),
        .i_index    (w_index),
        .i_coef     (w_coef),
        .i_recip    (w_recip),
        .i_corr     (w_corr),
        .i_shift    (w_shift),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    // queue decouples input stalls from output stalls
    jcq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_stat  (w_q_stat)
    );

    // back: three stage arithmetic pipeline, last stage is the output register
    jcq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (w_pop_entry),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_position  (w_position),
        .o_quantized (w_quantized)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W-IDX_W-COEF_W){1'b0}}, w_quantized, w_position};

    // input only stalls when the queue is full and a lookup waits for it
    `JCQ_ASSERT_IMPL(a_stall_needs_full, i_clk, i_rst_n, !o_s_axis_tready, w_q_stat.full, "input stalled while queue has room")
    // back never pops an empty queue
    `JCQ_ASSERT_IMPL(a_pop_needs_data, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "pop from empty queue")
    // an accepted quantize word is pending at the queue in the next cycle
    `JCQ_ASSERT_NEXT(a_quant_reaches_queue, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (w_op == OP_QUANT), w_push || w_q_stat.full, "quantize word lost after lookup")

endmodule

// ----- verif/testbench.sv -----
// testbench for jpeg_coef_quantizer: directed table walk, then random load/quantize traffic
// scores every result word against its lit value or a local reciprocal-multiply predictor
// depends on jcq_pkg and the jpeg_coef_quantizer rtl only
module testbench
    import jcq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // allowance for the pipeline, plus margin for the drain
    localparam int LATENCY      = 4;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    // worst case is ~525 words with their gaps and stalls plus one long hold, taken several times over
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 500;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 250;
    localparam int PRINT_LIMIT  = 30;

    // one input word, fields as typed values
    typedef struct {
        t_op                op;
        logic [5:0]         idx;
        logic signed [15:0] coef;
        logic [15:0]        recip;
        logic [15:0]        corr;
        logic [3:0]         shift;
        bit                 lit;     // row carries its own expected value
        logic signed [15:0] lit_q;
    } t_stim_row;

    // one expected result word
    typedef struct {
        logic [5:0]         position;
        logic signed [15:0] quantized;
    } t_quant_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // index[5:0], coef[21:6], recip[37:22], corr[53:38], shift[57:54], zero pad [63:58]
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    // op[0]: 0 load table entry, 1 quantize coefficient
    logic [0:0]           i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // position[5:0], quantized[21:6], zero pad [23:22]
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    jpeg_coef_quantizer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predictor copy of the three tables, plus which positions have been loaded
    logic [15:0] recip_mem [64];
    logic [15:0] corr_mem  [64];
    logic [3:0]  shift_mem [64];
    bit          loaded    [64];
    logic [5:0]  loaded_list [$];

    t_quant_word pending_results [$];

    int mismatches    = 0;
    int words_sent    = 0;
    int loads_sent    = 0;
    int quants_sent   = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    bit tx_no_gaps    = 1'b0;

    // directed table: extremes of every field, both ops, and the corner cases
    // lit rows carry values read straight off the arithmetic, the rest go to the predictor
    t_stim_row directed_rows [22] = '{
        // zero reciprocal gives zero for any coefficient
        '{OP_LOAD,  6'd0,  16'sh0000, 16'h0000, 16'h0000, 4'h0, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd0,  16'sh7fff, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh0000},
        // top position, full-scale reciprocal, no shift
        '{OP_LOAD,  6'd63, 16'sh0000, 16'hffff, 16'h0000, 4'h0, 1'b0, 16'sh0000},
        // most negative coefficient: magnitude is 32768
        '{OP_QUANT, 6'd63, 16'sh8000, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh8001},
        '{OP_QUANT, 6'd63, 16'sh7fff, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh7ffe},
        '{OP_QUANT, 6'd63, 16'sh0000, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh0000},
        // magnitude plus correction wraps to zero
        '{OP_LOAD,  6'd21, 16'sh0000, 16'hffff, 16'hffff, 4'h0, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd21, 16'sh0001, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh0000},
        '{OP_QUANT, 6'd21, 16'shffff, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh0000},
        // quotient with bit 15 set, sign put back modulo 2^16
        '{OP_LOAD,  6'd42, 16'sh0000, 16'hffff, 16'hfffe, 4'h0, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd42, 16'sh0001, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'shfffe},
        '{OP_QUANT, 6'd42, 16'shffff, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh0002},
        // largest extra shift
        '{OP_LOAD,  6'd7,  16'sh0000, 16'hffff, 16'h0000, 4'hf, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd7,  16'sh8000, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh0000},
        // divide by four: recip 0x8000 with one extra shift
        '{OP_LOAD,  6'd56, 16'sh0000, 16'h8000, 16'h0000, 4'h1, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd56, 16'sh0064, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'sh0019},
        '{OP_QUANT, 6'd56, 16'shff9c, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'shffe7},
        // ordinary entry with rounding correction
        '{OP_LOAD,  6'd35, 16'sh0000, 16'h2aab, 16'h0003, 4'h2, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd35, 16'sh1234, 16'h0000, 16'h0000, 4'h0, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd35, 16'sh8000, 16'h0000, 16'h0000, 4'h0, 1'b0, 16'sh0000},
        // reload an entry that was already written
        '{OP_LOAD,  6'd63, 16'sh0000, 16'h0001, 16'h0000, 4'h0, 1'b0, 16'sh0000},
        '{OP_QUANT, 6'd63, 16'sh8000, 16'h0000, 16'h0000, 4'h0, 1'b0, 16'sh0000}
    };

    // clock, 12 ns period
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on total run length
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results still pending",
                         cycle_count, pending_results.size());
                $display("[jpeg_coef_quantizer] ERROR");
                $finish;
            end
        end
    end

    // magnitude, add correction mod 2^16, multiply, logical shift by shift+16, sign back
    function automatic logic [15:0] quantize_coef(input logic [15:0] c, input logic [5:0] pos);
        logic [15:0] sgn;
        logic [15:0] mag;
        logic [15:0] sum;
        logic [31:0] prod;
        logic [15:0] q;
        sgn  = c[15] ? 16'hffff : 16'h0000;
        mag  = (c ^ sgn) - sgn;
        sum  = mag + corr_mem[pos];
        prod = {16'h0000, sum} * {16'h0000, recip_mem[pos]};
        q    = 16'((prod >> shift_mem[pos]) >> 16);
        return (q ^ sgn) - sgn;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // offer one word until it is taken, then update the predictor and idle for the picked gap, if any
    task automatic push_word(input t_stim_row row);
        t_quant_word exp_word;
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= row.op;
        i_s_axis_tdata  <= {6'b0, row.shift, row.corr, row.recip, row.coef, row.idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        words_sent++;
        if (row.op == OP_LOAD) begin
            loads_sent++;
            recip_mem[row.idx] = row.recip;
            corr_mem[row.idx]  = row.corr;
            shift_mem[row.idx] = row.shift;
            if (!loaded[row.idx]) begin
                loaded[row.idx] = 1'b1;
                loaded_list.push_back(row.idx);
            end
        end else begin
            quants_sent++;
            exp_word.position  = row.idx;
            exp_word.quantized = row.lit ? row.lit_q : quantize_coef(row.coef, row.idx);
            pending_results.push_back(exp_word);
        end
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            // ignored data is scrambled while idle
            i_s_axis_tdata  <= {6'b0, 58'($urandom()) ^ {$urandom(), 26'b0}};
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random coefficient, biased toward the extremes
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    // random table entry content, reaching full-scale reciprocals and wrapping corrections
    task automatic pick_entry(output logic [15:0] rc, output logic [15:0] cr,
                              output logic [3:0] sh);
        case ($urandom_range(0, 5))
            0: rc = 16'hffff;
            1: rc = 16'h0000;
            2: rc = 16'($urandom_range(1, 4095));
            default: rc = 16'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0: cr = 16'hffff - 16'($urandom_range(0, 255));
            1: cr = 16'h0000;
            2: cr = 16'($urandom());
            default: cr = 16'($urandom_range(0, 1023));
        endcase
        sh = 4'($urandom_range(0, 15));
    endtask

    // result side: score accepted words, random stalls, and one long hold-off
    initial begin
        t_quant_word exp_word;
        logic [5:0]  got_pos;
        logic [15:0] got_q;
        int  rx_cycles = 0;
        int  idle_left = 0;
        int  hold_left = 0;
        bit  hold_done = 1'b0;
        bit  stall_mode = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                got_pos = o_m_axis_tdata[5:0];
                got_q   = o_m_axis_tdata[21:6];
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pos %0d q %h", got_pos, got_q));
                end else begin
                    exp_word = pending_results.pop_front();
                    if (got_pos !== exp_word.position)
                        report_mismatch($sformatf("position got %0d want %0d",
                                                  got_pos, exp_word.position));
                    if (got_q !== exp_word.quantized)
                        report_mismatch($sformatf("quantized at pos %0d got %h want %h",
                                                  exp_word.position, got_q,
                                                  exp_word.quantized));
                end
            end
            rx_cycles++;
            if (rx_cycles % 40 == 0)
                stall_mode = ($urandom_range(0, 2) != 0);
            // one long hold so the pipe and queue fill and back-pressure the input
            if (!hold_done && words_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                i_m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                idle_left = stall_mode ? pick_gap() : 0;
            end
        end
    end

    // input side and end of run
    initial begin
        t_stim_row row;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table walk, ignored fields filled with noise
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.op == OP_LOAD) begin
                row.coef = 16'($urandom());
            end else begin
                row.recip = 16'($urandom());
                row.corr  = 16'($urandom());
                row.shift = 4'($urandom());
            end
            push_word(row);
        end

        // random traffic: mostly quantizes of loaded positions, some loads
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0)
                tx_no_gaps = ($urandom_range(0, 2) == 0);
            row.lit   = 1'b0;
            row.lit_q = '0;
            if ($urandom_range(0, 3) == 0) begin
                row.op   = OP_LOAD;
                row.idx  = 6'($urandom());
                row.coef = 16'($urandom());
                pick_entry(row.recip, row.corr, row.shift);
            end else begin
                // never quantize a position that was not loaded
                row.op    = OP_QUANT;
                row.idx   = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                row.coef  = pick_coef();
                row.recip = 16'($urandom());
                row.corr  = 16'($urandom());
                row.shift = 4'($urandom());
            end
            push_word(row);
        end
        i_s_axis_tvalid <= 1'b0;

        // drain, then watch a little longer for stray words
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d words (%0d table loads, %0d quantizes), %0d results scored",
                 words_sent, loads_sent, quants_sent, results_seen);
        $display("%0d of 64 positions loaded, %0d mismatches", loaded_list.size(), mismatches);
        if (mismatches == 0) begin
            $display("[jpeg_coef_quantizer] OK");
        end else begin
            $display("[jpeg_coef_quantizer] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/jcq_pkg.sv
hw/rtl/jcq_ram.sv
hw/rtl/jcq_front.sv
hw/rtl/jcq_queue.sv
hw/rtl/jcq_back.sv
hw/rtl/jpeg_coef_quantizer.sv
verif/testbench.sv
